>>> src/pmc_pkg.sv
// Package for the port mapping client controller.
// Holds the beat payload types, the request and reply codes and the register defaults.
// No dependencies; every other file of the block refers to it by scoped names.
package pmc_pkg;

  // Request kinds carried by each result beat.
  typedef enum logic [1:0] {
    REQ_NONE       = 2'd0,
    REQ_GETIP      = 2'd1,
    REQ_NATPMP_MAP = 2'd2,
    REQ_PCP_MAP    = 2'd3
  } req_kind_e;

  // Poll operations. The spare code is handled as a plain poll.
  localparam logic [1:0] OP_POLL  = 2'd0;
  localparam logic [1:0] OP_REPLY = 2'd1;
  localparam logic [1:0] OP_ERROR = 2'd2;
  localparam logic [1:0] OP_SPARE = 2'd3;

  // Reply decoding.
  localparam logic [7:0]  VER_NATPMP       = 8'd0;
  localparam logic [7:0]  VER_PCP          = 8'd2;
  localparam logic [7:0]  OPC_GETIP_REPLY  = 8'h80;
  localparam logic [7:0]  OPC_MAP_REPLY    = 8'h81;
  localparam logic [15:0] CODE_SUCCESS     = 16'd0;
  localparam logic [15:0] CODE_UNSUPPORTED = 16'd1;

  // Configuration register indexes.
  localparam logic [1:0] CFG_GATEWAY_IP  = 2'd0;
  localparam logic [1:0] CFG_TARGET_PORT = 2'd1;
  localparam logic [1:0] CFG_FPS         = 2'd2;

  localparam int unsigned CfgDataWidth = 32;

  // Register reset values.
  localparam logic [31:0] GATEWAY_IP_RST  = 32'd0;
  localparam logic [15:0] TARGET_PORT_RST = 16'd9103;
  localparam logic [7:0]  FPS_RST         = 8'd60;

  typedef struct packed {
    logic [31:0] gateway_ip;
    logic [15:0] target_port;
    logic [7:0]  frames_per_second;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] source_ip;
    logic [7:0]  version;
    logic [7:0]  opcode;
    logic [15:0] result_code;
    logic [31:0] epoch_value;
    logic [30:0] lifetime;
    logic [31:0] assigned_ip;
    logic [15:0] assigned_port;
  } poll_t;

  typedef struct packed {
    logic [1:0]  request_kind;
    logic        last_result;
    logic        mapping_ok;
    logic        gave_up;
    logic [31:0] external_ip;
    logic [15:0] mapped_port;
    logic [31:0] server_epoch;
  } result_t;

  // Status shared by every beat of one poll.
  typedef struct packed {
    logic        mapping_ok;
    logic        gave_up;
    logic [31:0] external_ip;
    logic [15:0] mapped_port;
    logic [31:0] server_epoch;
  } status_t;

  // Everything one poll produces: up to three requests in send order.
  typedef struct packed {
    req_kind_e [2:0] reqs;
    logic [1:0]      cnt;
    status_t         status;
  } rec_t;

endpackage

>>> src/pmc_if.sv
// Valid/ready channel interfaces of the port mapping client controller.
// Depends on pmc_pkg for the payload types.
interface pmc_poll_if;
  logic          valid;
  logic          ready;
  pmc_pkg::poll_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pmc_result_if;
  logic            valid;
  logic            ready;
  pmc_pkg::result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> src/port_mapping_client_controller.sv
// Top level of the port mapping client controller (PCP first, NAT-PMP fallback).
// Depends on pmc_pkg, the channel interfaces in pmc_if.sv and the pmc_poll module.
//
// Usage: one beat on poll_i is one poll, normally one per frame, optionally carrying
// a parsed gateway reply or a socket error. For every poll the block sends one to
// three beats on result_o, one per request to send (or a single status beat with
// request kind none); the last beat of a poll has last_result set, and every beat
// of a poll carries the status as it stands after that poll.
// Configuration: cfg_we_i writes cfg_wdata_i into the register chosen by cfg_idx_i
// (gateway address, target port, frames per second) at the same clock edge. Writes
// must be made only while no poll is in flight; the block itself does not enforce this.
// A poll beat accepted on poll_i is held in the input register, evaluated in one
// pass and the outcome captured in the result register, which then issues its
// beats one per cycle while the receiver is ready. Throughput is one poll per
// cycle while each poll yields a single beat and the receiver does not stall; a
// poll with several requests holds the result register until its last beat leaves.
// Reset: the client returns to not started, no mapping, epoch zero, and the
// registers to their defaults. When the receiver stalls, the result register holds
// its beat and the input register still takes one more poll before poll_i.ready
// drops.
module port_mapping_client_controller (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  pmc_poll_if.sink                            poll_i,
  pmc_result_if.source                        result_o,
  input  logic                                cfg_we_i,
  input  logic [1:0]                          cfg_idx_i,
  input  logic [pmc_pkg::CfgDataWidth-1:0]    cfg_wdata_i
);

  // Configuration registers.
  pmc_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gateway_ip        <= pmc_pkg::GATEWAY_IP_RST;
      cfg_q.target_port       <= pmc_pkg::TARGET_PORT_RST;
      cfg_q.frames_per_second <= pmc_pkg::FPS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pmc_pkg::CFG_GATEWAY_IP:  cfg_q.gateway_ip        <= cfg_wdata_i[31:0];
        pmc_pkg::CFG_TARGET_PORT: cfg_q.target_port       <= cfg_wdata_i[15:0];
        pmc_pkg::CFG_FPS:         cfg_q.frames_per_second <= cfg_wdata_i[7:0];
        default: ;  // Unused index: the write is dropped.
      endcase
    end
  end

  // Input register: it still takes one poll while the result side is stalled.
  logic           in_vld_q;
  pmc_pkg::poll_t in_q;

  // Result register: the outcome of one poll and the index of the beat on show.
  logic           res_vld_q;
  pmc_pkg::rec_t  res_rec_q;
  logic [1:0]     res_idx_q;

  pmc_pkg::rec_t  rec_d;
  logic           res_last;
  logic           res_free;
  logic           xfer;

  assign res_last = (res_idx_q == res_rec_q.cnt - 2'd1);
  // The result register is free when empty or when its last beat leaves now.
  assign res_free = !res_vld_q || (result_o.ready && res_last);
  // The poll in the input register is evaluated and the client state advanced.
  assign xfer     = in_vld_q && res_free;

  assign poll_i.ready = !in_vld_q || xfer;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (poll_i.ready) begin
      in_vld_q <= poll_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (poll_i.ready && poll_i.valid) begin
      in_q <= poll_i.data;
    end
  end

  pmc_poll u_poll (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (xfer),
    .poll_i (in_q),
    .cfg_i  (cfg_q),
    .rec_o  (rec_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
      res_idx_q <= 2'd0;
    end else if (xfer) begin
      res_vld_q <= 1'b1;
      res_idx_q <= 2'd0;
    end else if (res_vld_q && result_o.ready) begin
      if (res_last) begin
        res_vld_q <= 1'b0;
        res_idx_q <= 2'd0;
      end else begin
        res_idx_q <= res_idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (xfer) begin
      res_rec_q <= rec_d;
    end
  end

  assign result_o.valid              = res_vld_q;
  assign result_o.data.request_kind  = res_rec_q.reqs[res_idx_q];
  assign result_o.data.last_result   = res_last;
  assign result_o.data.mapping_ok    = res_rec_q.status.mapping_ok;
  assign result_o.data.gave_up       = res_rec_q.status.gave_up;
  assign result_o.data.external_ip   = res_rec_q.status.external_ip;
  assign result_o.data.mapped_port   = res_rec_q.status.mapped_port;
  assign result_o.data.server_epoch  = res_rec_q.status.server_epoch;

  // The beat index never runs past the number of requests of the poll.
  a_idx_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_q |-> (res_idx_q < res_rec_q.cnt))
    else $error("result beat index out of range");

  // An evaluated poll always starts on its first beat.
  a_xfer_first : assert property (@(posedge clk_i) disable iff (!rst_ni)
    xfer |=> (res_vld_q && res_idx_q == 2'd0))
    else $error("evaluated poll not presented from its first beat");

  // A poll waiting in the input register is never dropped.
  a_in_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !xfer) |=> in_vld_q)
    else $error("pending poll lost");

endmodule

>>> src/pmc_poll.sv
// Client state and the single-pass poll logic of the port mapping client controller.
// Depends on pmc_pkg; instantiated by port_mapping_client_controller.
module pmc_poll (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           fire_i,
  input  pmc_pkg::poll_t poll_i,
  input  pmc_pkg::cfg_t  cfg_i,
  output pmc_pkg::rec_t  rec_o
);

  logic        started_q, started_d;
  logic        dead_q, dead_d;
  logic        pcp_rej_q, pcp_rej_d;
  logic        nat_rej_q, nat_rej_d;
  logic [7:0]  frame_q, frame_d;
  logic [31:0] epoch_q, epoch_d;
  // The expiry countdown is either absent (no mapping) or a 31-bit count.
  logic        exp_none_q, exp_none_d;
  logic [30:0] exp_cnt_q, exp_cnt_d;
  logic        granted_q, granted_d;
  logic [31:0] addr_q, addr_d;
  logic [15:0] port_q, port_d;

  always_comb begin
    logic                  start_req;
    logic                  mid_req_v;
    pmc_pkg::req_kind_e    mid_req;
    logic                  renew;
    logic                  check_renew;
    logic [1:0]            k;

    started_d   = started_q;
    dead_d      = dead_q;
    pcp_rej_d   = pcp_rej_q;
    nat_rej_d   = nat_rej_q;
    frame_d     = frame_q;
    epoch_d     = epoch_q;
    exp_none_d  = exp_none_q;
    exp_cnt_d   = exp_cnt_q;
    granted_d   = granted_q;
    addr_d      = addr_q;
    port_d      = port_q;
    start_req   = 1'b0;
    mid_req_v   = 1'b0;
    mid_req     = pmc_pkg::REQ_NONE;
    renew       = 1'b0;
    check_renew = 1'b1;

    // A second passes once the frame count reaches the configured period.
    if (frame_q >= cfg_i.frames_per_second) begin
      epoch_d = epoch_q + 32'd1;
      if (!exp_none_q && exp_cnt_q != 31'd0) begin
        exp_cnt_d = exp_cnt_q - 31'd1;
      end
      frame_d = 8'd0;
    end else begin
      frame_d = frame_q + 8'd1;
    end

    if (!dead_q) begin
      if (!started_q) begin
        started_d = 1'b1;
        start_req = 1'b1;
      end

      if (poll_i.op == pmc_pkg::OP_REPLY) begin
        priority if (poll_i.source_ip != cfg_i.gateway_ip) begin
          check_renew = 1'b0;
        end else if (poll_i.result_code == pmc_pkg::CODE_UNSUPPORTED) begin
          check_renew = 1'b0;
          if (!pcp_rej_q) begin
            pcp_rej_d = 1'b1;
            mid_req_v = 1'b1;
            mid_req   = pmc_pkg::REQ_GETIP;
          end else begin
            nat_rej_d = 1'b1;
          end
        end else if (poll_i.result_code == pmc_pkg::CODE_SUCCESS &&
                     poll_i.version == pmc_pkg::VER_NATPMP &&
                     poll_i.opcode == pmc_pkg::OPC_GETIP_REPLY) begin
          epoch_d   = poll_i.epoch_value;
          addr_d    = poll_i.assigned_ip;
          mid_req_v = 1'b1;
          mid_req   = pmc_pkg::REQ_NATPMP_MAP;
        end else if (poll_i.result_code == pmc_pkg::CODE_SUCCESS &&
                     poll_i.opcode == pmc_pkg::OPC_MAP_REPLY &&
                     (poll_i.version == pmc_pkg::VER_NATPMP ||
                      poll_i.version == pmc_pkg::VER_PCP)) begin
          epoch_d    = poll_i.epoch_value;
          exp_none_d = 1'b0;
          exp_cnt_d  = poll_i.lifetime;
          port_d     = poll_i.assigned_port;
          if (poll_i.assigned_port == cfg_i.target_port) begin
            granted_d = 1'b1;
          end
          if (poll_i.version == pmc_pkg::VER_PCP) begin
            addr_d = poll_i.assigned_ip;
          end
        end else begin
          // Any other reply leaves the state alone.
        end
      end else if (poll_i.op == pmc_pkg::OP_ERROR) begin
        dead_d = 1'b1;
      end

      // Ask again for the mapping when its lifetime has run out.
      if (check_renew && !dead_d && !exp_none_d && exp_cnt_d == 31'd0) begin
        exp_none_d = 1'b1;
        renew      = 1'b1;
      end
    end

    // Pack the requests in send order; a silent poll still yields one beat.
    rec_o.reqs = {3{pmc_pkg::REQ_NONE}};
    k = 2'd0;
    if (start_req) begin
      rec_o.reqs[k] = pmc_pkg::REQ_PCP_MAP;
      k = k + 2'd1;
    end
    if (mid_req_v) begin
      rec_o.reqs[k] = mid_req;
      k = k + 2'd1;
    end
    if (renew) begin
      rec_o.reqs[k] = pcp_rej_d ? pmc_pkg::REQ_NATPMP_MAP : pmc_pkg::REQ_PCP_MAP;
      k = k + 2'd1;
    end
    rec_o.cnt = (k == 2'd0) ? 2'd1 : k;

    rec_o.status.mapping_ok   = granted_d;
    rec_o.status.gave_up      = nat_rej_d;
    rec_o.status.external_ip  = addr_d;
    rec_o.status.mapped_port  = port_d;
    rec_o.status.server_epoch = epoch_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q  <= 1'b0;
      dead_q     <= 1'b0;
      pcp_rej_q  <= 1'b0;
      nat_rej_q  <= 1'b0;
      frame_q    <= 8'd0;
      epoch_q    <= 32'd0;
      exp_none_q <= 1'b1;
      exp_cnt_q  <= 31'd0;
      granted_q  <= 1'b0;
      addr_q     <= 32'd0;
      port_q     <= 16'd0;
    end else if (fire_i) begin
      started_q  <= started_d;
      dead_q     <= dead_d;
      pcp_rej_q  <= pcp_rej_d;
      nat_rej_q  <= nat_rej_d;
      frame_q    <= frame_d;
      epoch_q    <= epoch_d;
      exp_none_q <= exp_none_d;
      exp_cnt_q  <= exp_cnt_d;
      granted_q  <= granted_d;
      addr_q     <= addr_d;
      port_q     <= port_d;
    end
  end

  // Once the socket is gone it stays gone.
  a_dead_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    dead_q |=> dead_q)
    else $error("link dead flag cleared");

  // NAT-PMP rejection can only follow a PCP rejection.
  a_reject_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    nat_rej_q |-> pcp_rej_q)
    else $error("NAT-PMP rejected before PCP");

  // A dead link sends no request at all.
  a_dead_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    dead_q |-> (rec_o.cnt == 2'd1 && rec_o.reqs[0] == pmc_pkg::REQ_NONE))
    else $error("request issued on a dead link");

endmodule

>>> verif/port_mapping_client_controller_tb.sv
// Self-checking testbench of the port mapping client controller.
// Depends on pmc_pkg, the channel interfaces in pmc_if.sv and the block's top level.
// A behavioral client model predicts every result beat, and a monitor checks each one.
module port_mapping_client_controller_tb;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldCycles = 60;
  localparam int unsigned SettleCycles = 8;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [pmc_pkg::CfgDataWidth-1:0] cfg_wdata_i;

  pmc_poll_if poll_bus ();
  pmc_result_if result_bus ();

  port_mapping_client_controller dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .poll_i     (poll_bus),
    .result_o   (result_bus),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // Register copies, kept in step with every configuration write.
  logic [31:0] gateway_cfg = pmc_pkg::GATEWAY_IP_RST;
  logic [15:0] target_port_cfg = pmc_pkg::TARGET_PORT_RST;
  logic [7:0] fps_cfg = pmc_pkg::FPS_RST;

  // Client state of the model, at its reset values.
  bit started = 1'b0;
  bit link_dead = 1'b0;
  bit pcp_rejected = 1'b0;
  bit natpmp_rejected = 1'b0;
  logic [7:0] frame_cnt = '0;
  logic [31:0] epoch_cnt = '0;
  longint expiry_left = -1;
  bit granted = 1'b0;
  logic [31:0] ext_address = '0;
  logic [15:0] ext_port_held = '0;

  pmc_pkg::poll_t polls_to_send_q[$];
  pmc_pkg::result_t beats_due_q[$];

  int unsigned err_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned sender_idle_pct = 0;
  int unsigned receiver_stall_pct = 0;
  int unsigned hold_asked = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left = 0;
  bit poll_taken = 1'b0;

  // Runs one poll through the client model and queues the beats it must produce.
  // The order is fixed: seconds tick, start-up request, reply handling, renewal.
  function automatic void advance_client(input pmc_pkg::poll_t p);
    pmc_pkg::req_kind_e reqs[$];
    pmc_pkg::result_t beat;
    bit renew_ok;
    renew_ok = 1'b1;
    if (frame_cnt >= fps_cfg) begin
      epoch_cnt = epoch_cnt + 32'd1;
      if (expiry_left > 0) expiry_left--;
      frame_cnt = '0;
    end else begin
      frame_cnt = frame_cnt + 8'd1;
    end
    if (!started && !link_dead) begin
      started = 1'b1;
      reqs.push_back(pmc_pkg::REQ_PCP_MAP);
    end
    if (started && !link_dead) begin
      if (p.op == pmc_pkg::OP_REPLY) begin
        if (p.source_ip != gateway_cfg) begin
          renew_ok = 1'b0;
        end else if (p.result_code == pmc_pkg::CODE_UNSUPPORTED) begin
          // The first rejection drops to NAT-PMP, any later one means giving up.
          renew_ok = 1'b0;
          if (!pcp_rejected) begin
            pcp_rejected = 1'b1;
            reqs.push_back(pmc_pkg::REQ_GETIP);
          end else begin
            natpmp_rejected = 1'b1;
          end
        end else if (p.result_code == pmc_pkg::CODE_SUCCESS &&
                     p.version == pmc_pkg::VER_NATPMP &&
                     p.opcode == pmc_pkg::OPC_GETIP_REPLY) begin
          epoch_cnt = p.epoch_value;
          ext_address = p.assigned_ip;
          reqs.push_back(pmc_pkg::REQ_NATPMP_MAP);
        end else if (p.result_code == pmc_pkg::CODE_SUCCESS &&
                     p.opcode == pmc_pkg::OPC_MAP_REPLY &&
                     (p.version == pmc_pkg::VER_NATPMP ||
                      p.version == pmc_pkg::VER_PCP)) begin
          epoch_cnt = p.epoch_value;
          expiry_left = p.lifetime;
          if (p.version == pmc_pkg::VER_PCP) ext_address = p.assigned_ip;
          ext_port_held = p.assigned_port;
          if (p.assigned_port == target_port_cfg) granted = 1'b1;
        end
      end else if (p.op == pmc_pkg::OP_ERROR) begin
        link_dead = 1'b1;
      end
      if (renew_ok && !link_dead && expiry_left == 0) begin
        expiry_left = -1;
        reqs.push_back(pcp_rejected ? pmc_pkg::REQ_NATPMP_MAP : pmc_pkg::REQ_PCP_MAP);
      end
    end
    if (reqs.size() == 0) reqs.push_back(pmc_pkg::REQ_NONE);
    foreach (reqs[k]) begin
      beat.request_kind = reqs[k];
      beat.last_result = (k == reqs.size() - 1);
      beat.mapping_ok = granted;
      beat.gave_up = natpmp_rejected;
      beat.external_ip = ext_address;
      beat.mapped_port = ext_port_held;
      beat.server_epoch = epoch_cnt;
      beats_due_q.push_back(beat);
    end
  endfunction

  // A poll of the given kind with every reply field random.
  function automatic pmc_pkg::poll_t mk_poll(input logic [1:0] op);
    pmc_pkg::poll_t p;
    p.op = op;
    p.source_ip = $urandom;
    p.version = 8'($urandom);
    p.opcode = 8'($urandom);
    p.result_code = 16'($urandom);
    p.epoch_value = $urandom;
    p.lifetime = 31'($urandom);
    p.assigned_ip = $urandom;
    p.assigned_port = 16'($urandom);
    return p;
  endfunction

  // A reply from the gateway with random epoch and address.
  function automatic pmc_pkg::poll_t mk_reply(input logic [7:0] ver, input logic [7:0] opc,
                                              input logic [15:0] code,
                                              input logic [30:0] life,
                                              input logic [15:0] port);
    pmc_pkg::poll_t p;
    p = mk_poll(pmc_pkg::OP_REPLY);
    p.source_ip = gateway_cfg;
    p.version = ver;
    p.opcode = opc;
    p.result_code = code;
    p.lifetime = life;
    p.assigned_port = port;
    return p;
  endfunction

  // Mostly plain polls and well-formed exchanges with short lifetimes so that
  // renewals come often; the rest are foreign sources, rejections and malformed replies.
  function automatic pmc_pkg::poll_t rand_poll();
    pmc_pkg::poll_t p;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 35) begin
      p = mk_poll(pmc_pkg::OP_POLL);
      if ($urandom_range(3) == 0) p.op = pmc_pkg::OP_SPARE;
    end else if (pick < 50) begin
      p = mk_reply(pmc_pkg::VER_NATPMP, pmc_pkg::OPC_GETIP_REPLY, pmc_pkg::CODE_SUCCESS,
                   31'($urandom), 16'($urandom));
    end else if (pick < 75) begin
      p = mk_reply($urandom_range(1) ? pmc_pkg::VER_PCP : pmc_pkg::VER_NATPMP,
                   pmc_pkg::OPC_MAP_REPLY, pmc_pkg::CODE_SUCCESS,
                   31'($urandom_range(4)),
                   $urandom_range(1) ? target_port_cfg : 16'($urandom));
      if ($urandom_range(15) == 0) p.lifetime = 31'($urandom);
    end else if (pick < 82) begin
      p = mk_reply(8'($urandom), 8'($urandom), pmc_pkg::CODE_UNSUPPORTED, 31'($urandom),
                   16'($urandom));
    end else if (pick < 91) begin
      p = mk_reply(pmc_pkg::VER_PCP, pmc_pkg::OPC_MAP_REPLY, pmc_pkg::CODE_SUCCESS,
                   31'($urandom_range(2)), target_port_cfg);
      p.source_ip = gateway_cfg ^ ($urandom | 32'd1);
    end else begin
      // Broken reply from the gateway: plausible header with a bad code, or junk.
      p = mk_poll(pmc_pkg::OP_REPLY);
      p.source_ip = gateway_cfg;
      if ($urandom_range(1)) begin
        p.version = $urandom_range(1) ? pmc_pkg::VER_PCP : pmc_pkg::VER_NATPMP;
        p.opcode = $urandom_range(1) ? pmc_pkg::OPC_MAP_REPLY : pmc_pkg::OPC_GETIP_REPLY;
        p.result_code = 16'($urandom_range(65535, 2));
      end
    end
    return p;
  endfunction

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= value;
    case (idx)
      pmc_pkg::CFG_GATEWAY_IP: gateway_cfg = value;
      pmc_pkg::CFG_TARGET_PORT: target_port_cfg = value[15:0];
      pmc_pkg::CFG_FPS: fps_cfg = value[7:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Waits until every poll is sent and every predicted beat has been seen, then
  // lets the block settle so the next configuration write finds it idle.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (polls_to_send_q.size() != 0 || poll_bus.valid || beats_due_q.size() != 0);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic run_phase(input logic [31:0] gw, input logic [15:0] port,
                           input logic [7:0] fps, input int unsigned idle_pct,
                           input int unsigned stall_pct, input int unsigned n_polls);
    cfg_write(pmc_pkg::CFG_GATEWAY_IP, gw);
    cfg_write(pmc_pkg::CFG_TARGET_PORT, {16'd0, port});
    cfg_write(pmc_pkg::CFG_FPS, {24'd0, fps});
    sender_idle_pct = idle_pct;
    receiver_stall_pct = stall_pct;
    repeat (n_polls) polls_to_send_q.push_back(rand_poll());
    wait_drained();
  endtask

  // Sender: a new poll beat may be offered only once the previous one was taken.
  always @(negedge clk_i) begin
    if (rst_ni && !(poll_bus.valid && !poll_taken)) begin
      if (polls_to_send_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        poll_bus.valid <= 1'b1;
        poll_bus.data <= polls_to_send_q.pop_front();
      end else begin
        poll_bus.valid <= 1'b0;
      end
    end
    poll_taken = 1'b0;
  end

  // Receiver: random stalls, plus a long hold-off whenever one is requested.
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      result_bus.ready <= 1'b0;
      hold_left--;
    end else if (hold_served != hold_asked) begin
      hold_served = hold_asked;
      hold_left = HoldCycles - 1;
      result_bus.ready <= 1'b0;
    end else begin
      result_bus.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      err_cnt++;
    end
  endtask

  // Monitor and predictor share one process: result beats are checked before a
  // poll accepted at the same edge adds its predictions.
  always @(posedge clk_i) begin
    pmc_pkg::result_t want;
    if (result_bus.valid && result_bus.ready) begin
      if (beats_due_q.size() == 0) begin
        $error("result beat 0x%0h arrived with no beat expected", result_bus.data);
        err_cnt++;
      end else begin
        want = beats_due_q.pop_front();
        check_field("request_kind", result_bus.data.request_kind, want.request_kind);
        check_field("last_result", result_bus.data.last_result, want.last_result);
        check_field("mapping_ok", result_bus.data.mapping_ok, want.mapping_ok);
        check_field("gave_up", result_bus.data.gave_up, want.gave_up);
        check_field("external_ip", result_bus.data.external_ip, want.external_ip);
        check_field("mapped_port", result_bus.data.mapped_port, want.mapped_port);
        check_field("server_epoch", result_bus.data.server_epoch, want.server_epoch);
      end
    end
    if (poll_bus.valid && poll_bus.ready) begin
      advance_client(poll_bus.data);
      poll_taken = 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("port_mapping_client_controller regression: fail");
      $finish;
    end
  end

  initial begin
    pmc_pkg::poll_t p;
    poll_bus.valid = 1'b0;
    poll_bus.data = '0;
    result_bus.ready = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = pmc_pkg::CFG_GATEWAY_IP;
    cfg_wdata_i = '0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, no idling. A second passes on every other poll.
    cfg_write(pmc_pkg::CFG_GATEWAY_IP, 32'h0a00_0001);
    cfg_write(pmc_pkg::CFG_TARGET_PORT, 32'd9103);
    cfg_write(pmc_pkg::CFG_FPS, 32'd1);

    // The first poll starts the client and also carries a get-IP reply.
    polls_to_send_q.push_back(mk_reply(pmc_pkg::VER_NATPMP, pmc_pkg::OPC_GETIP_REPLY,
                                       pmc_pkg::CODE_SUCCESS, '0, '0));
    // PCP grant with zero lifetime renews within the same poll.
    polls_to_send_q.push_back(mk_reply(pmc_pkg::VER_PCP, pmc_pkg::OPC_MAP_REPLY,
                                       pmc_pkg::CODE_SUCCESS, '0, target_port_cfg));
    // A short lifetime for another port, then plain polls until it runs out.
    polls_to_send_q.push_back(mk_reply(pmc_pkg::VER_PCP, pmc_pkg::OPC_MAP_REPLY,
                                       pmc_pkg::CODE_SUCCESS, 31'd1, ~target_port_cfg));
    polls_to_send_q.push_back('0);
    polls_to_send_q.push_back(mk_poll(pmc_pkg::OP_SPARE));
    polls_to_send_q.push_back(mk_poll(pmc_pkg::OP_POLL));
    // A valid-looking grant from a foreign source is ignored.
    p = mk_reply(pmc_pkg::VER_PCP, pmc_pkg::OPC_MAP_REPLY, pmc_pkg::CODE_SUCCESS, '0,
                 target_port_cfg);
    p.source_ip = ~gateway_cfg;
    polls_to_send_q.push_back(p);
    // Replies with an unknown version, opcode or code change nothing.
    polls_to_send_q.push_back(mk_reply(8'd1, pmc_pkg::OPC_MAP_REPLY,
                                       pmc_pkg::CODE_SUCCESS, '0, '0));
    polls_to_send_q.push_back(mk_reply(pmc_pkg::VER_NATPMP, 8'h7f,
                                       pmc_pkg::CODE_SUCCESS, '0, '0));
    polls_to_send_q.push_back(mk_reply(pmc_pkg::VER_PCP, pmc_pkg::OPC_GETIP_REPLY,
                                       pmc_pkg::CODE_SUCCESS, '0, '0));
    polls_to_send_q.push_back(mk_reply(pmc_pkg::VER_PCP, pmc_pkg::OPC_MAP_REPLY,
                                       16'hffff, '0, '0));
    // NAT-PMP grant with epoch, address and port at their top values; the epoch wraps on the next second.
    p = mk_reply(pmc_pkg::VER_NATPMP, pmc_pkg::OPC_MAP_REPLY, pmc_pkg::CODE_SUCCESS, '0,
                 16'hffff);
    p.epoch_value = '1;
    p.assigned_ip = '1;
    polls_to_send_q.push_back(p);
    p = '1;
    p.op = pmc_pkg::OP_POLL;
    polls_to_send_q.push_back(p);
    polls_to_send_q.push_back(mk_poll(pmc_pkg::OP_POLL));
    // First rejection falls back to NAT-PMP, renewals then use NAT-PMP maps.
    polls_to_send_q.push_back(mk_reply(pmc_pkg::VER_PCP, pmc_pkg::OPC_MAP_REPLY,
                                       pmc_pkg::CODE_UNSUPPORTED, '0, '0));
    p = mk_reply(pmc_pkg::VER_NATPMP, pmc_pkg::OPC_GETIP_REPLY, pmc_pkg::CODE_SUCCESS,
                 '0, '0);
    p.epoch_value = '0;
    p.assigned_ip = '0;
    polls_to_send_q.push_back(p);
    polls_to_send_q.push_back(mk_reply(pmc_pkg::VER_NATPMP, pmc_pkg::OPC_MAP_REPLY,
                                       pmc_pkg::CODE_SUCCESS, '0, '0));
    // Second rejection gives up; rejections and foreign replies block the renewal.
    polls_to_send_q.push_back(mk_reply(pmc_pkg::VER_NATPMP, pmc_pkg::OPC_MAP_REPLY,
                                       pmc_pkg::CODE_SUCCESS, 31'd1, target_port_cfg));
    polls_to_send_q.push_back(mk_reply(pmc_pkg::VER_NATPMP, '0,
                                       pmc_pkg::CODE_UNSUPPORTED, '0, '0));
    polls_to_send_q.push_back(mk_reply(pmc_pkg::VER_NATPMP, '0,
                                       pmc_pkg::CODE_UNSUPPORTED, '0, '0));
    polls_to_send_q.push_back(mk_poll(pmc_pkg::OP_POLL));
    p = mk_reply(pmc_pkg::VER_NATPMP, pmc_pkg::OPC_MAP_REPLY, pmc_pkg::CODE_SUCCESS,
                 31'd1, '0);
    polls_to_send_q.push_back(p);
    p.source_ip = gateway_cfg ^ 32'h8000_0000;
    polls_to_send_q.push_back(p);
    polls_to_send_q.push_back(p);
    polls_to_send_q.push_back(mk_poll(pmc_pkg::OP_POLL));
    polls_to_send_q.push_back(mk_reply(pmc_pkg::VER_PCP, pmc_pkg::OPC_MAP_REPLY,
                                       pmc_pkg::CODE_SUCCESS, 31'h7fff_ffff,
                                       target_port_cfg));
    wait_drained();

    // Random phases, each with its own register setting and idling mix.
    run_phase(32'h0000_0000, 16'h0000, 8'd1, 0, 0, 65);
    run_phase(32'hffff_ffff, 16'hffff, 8'd2, 62, 0, 65);
    run_phase($urandom, 16'($urandom), 8'd255, 0, 62, 65);
    run_phase($urandom, 16'd9103, 8'($urandom_range(4, 1)), 14, 14, 65);

    // Back-pressure: the receiver holds off while polls keep coming, so the
    // block fills up and must drop poll ready.
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    hold_asked++;
    repeat (14) polls_to_send_q.push_back(rand_poll());
    wait_drained();

    // A socket error kills the link for good: afterwards only status beats.
    sender_idle_pct = 14;
    receiver_stall_pct = 14;
    polls_to_send_q.push_back(mk_poll(pmc_pkg::OP_ERROR));
    polls_to_send_q.push_back(mk_reply(pmc_pkg::VER_NATPMP, pmc_pkg::OPC_GETIP_REPLY,
                                       pmc_pkg::CODE_SUCCESS, '0, '0));
    polls_to_send_q.push_back(mk_reply(pmc_pkg::VER_PCP, pmc_pkg::OPC_MAP_REPLY,
                                       pmc_pkg::CODE_SUCCESS, '0, target_port_cfg));
    polls_to_send_q.push_back(mk_reply(pmc_pkg::VER_PCP, '0,
                                       pmc_pkg::CODE_UNSUPPORTED, '0, '0));
    repeat (6) polls_to_send_q.push_back(rand_poll());
    wait_drained();

    if (err_cnt == 0) begin
      $display("port_mapping_client_controller regression: pass");
    end else begin
      $display("port_mapping_client_controller regression: fail");
    end
    $finish;
  end

endmodule
